@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the Legendre series block.
// The user module must have a clock named clk and an active-low reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/lps_pkg.sv @@
// Shared types and constants of the Legendre polynomial series block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package lps_pkg;

	localparam int DEG_W         = 4;
	localparam int POS_W         = 32;
	localparam int VAL_W         = 32;
	localparam int MAX_ORDER     = 15;
	localparam int FRAC_BITS_DEF = 30;

	// highest degree that can ever be emitted
	localparam logic [DEG_W-1:0] TOP_LIMIT =
		(MAX_ORDER < (1 << DEG_W) - 1) ? DEG_W'(MAX_ORDER) : '1;

	// front-to-back queue, power of two
	localparam int QUEUE_DEPTH = 2;

	// quotient bits resolved per cycle in the divider
	localparam int DIV_BITS_PER_CYC = 4;

	// one classified transaction waiting for the back end
	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic [DEG_W-1:0]        top_degree;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_sts_t;

	typedef struct packed {
		logic             start;
		logic [DEG_W-1:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

@@ src/lps_queue.sv @@
// Short FIFO between the front and back ends of the Legendre series block.
// Depends on lps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lps_pkg::item_t  push_item,
	input  logic            pop,
	output lps_pkg::item_t  pop_item,
	output lps_pkg::q_sts_t sts
);
	import lps_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t         entry_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign sts.full  = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign sts.empty = (count_q == '0);
	assign pop_item  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)      count_q <= count_q + (AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (AW+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

	`ASSERT_IMPL(a_no_overflow, push, !sts.full, "queue written while full")
	`ASSERT_IMPL(a_no_underflow, pop, !sts.empty, "queue read while empty")

endmodule

@@ src/lps_front.sv @@
// Front end: holds max_degree, accepts positions, clamps them to [-1, 1]
// and tags each with its highest degree. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_front #(
	parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lps_pkg::DEG_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [lps_pkg::POS_W-1:0] position,
	input  lps_pkg::q_sts_t                q_sts,
	output logic                           push,
	output lps_pkg::item_t                 push_item
);
	import lps_pkg::*;

	localparam logic signed [POS_W-1:0] ONE_Q = POS_W'(longint'(1) << FRAC_BITS);

	logic [DEG_W-1:0] max_degree_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= '0;
		end else if (cfg_wr_en) begin
			max_degree_q <= cfg_wr_data;
		end
	end

	assign in_stall = q_sts.full;
	assign push     = in_valid && !q_sts.full;

	// clamp x and limit the degree
	always_comb begin
		if (position > ONE_Q)       push_item.position = ONE_Q;
		else if (position < -ONE_Q) push_item.position = -ONE_Q;
		else                        push_item.position = position;
		push_item.top_degree = (max_degree_q > TOP_LIMIT) ? TOP_LIMIT : max_degree_q;
	end

endmodule

@@ src/lps_div.sv @@
// Radix-16 restoring divider: wide unsigned dividend by a 4-bit divisor.
// Depends on lps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lps_div #(
	parameter int DIV_W = 36
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lps_pkg::div_ctl_t         ctl,
	input  logic [DIV_W-1:0]          dividend,
	output lps_pkg::div_sts_t         sts,
	output logic [DIV_W-1:0]          quotient
);
	import lps_pkg::*;

	localparam int DIV_CYC = DIV_W / DIV_BITS_PER_CYC;
	localparam int CW      = $clog2(DIV_CYC + 1);

	logic [DIV_W-1:0] work_q;
	logic [DEG_W-1:0] rem_q;
	logic [DEG_W-1:0] divisor_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;

	logic [DIV_W-1:0] work_n;
	logic [DEG_W-1:0] rem_n;
	logic [DEG_W:0]   trial;

	// a few restoring steps per cycle; remainder stays below the divisor
	always_comb begin
		work_n = work_q;
		rem_n  = rem_q;
		trial  = '0;
		for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
			trial  = {rem_n, work_n[DIV_W-1]};
			work_n = {work_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				rem_n     = DEG_W'(trial - {1'b0, divisor_q});
				work_n[0] = 1'b1;
			end else begin
				rem_n = trial[DEG_W-1:0];
			end
		end
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= CW'(DIV_CYC);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= ctl.divisor;
		end else if (cnt_q != '0) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quotient = work_q;

	`ASSERT_IMPL(a_start_idle, ctl.start, !sts.busy, "divider started while busy")
	`ASSERT_NEXT(a_start_busy, ctl.start, sts.busy && !sts.done, "divider did not start")

endmodule

@@ src/lps_back.sv @@
// Back end: runs Bonnet's recurrence for one queued position and drives
// the registered result channel. Depends on lps_pkg, lps_div, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lps_back #(
	parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lps_pkg::q_sts_t                  q_sts,
	input  lps_pkg::item_t                   pop_item,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lps_pkg::DEG_W-1:0]        degree,
	output logic signed [lps_pkg::VAL_W-1:0] poly_value,
	output logic                             last
);
	import lps_pkg::*;

	localparam int VW    = FRAC_BITS + 2;
	localparam int PW    = 2 * VW;
	localparam int NW    = 2 * FRAC_BITS + 7;
	localparam int DIV_W = DIV_BITS_PER_CYC *
		((FRAC_BITS + 6 + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC);
	localparam logic signed [VW-1:0] ONE_V = VW'(longint'(1) << FRAC_BITS);
	localparam logic [DIV_W-1:0]     ONE_D = DIV_W'(longint'(1) << FRAC_BITS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PUT   = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_ROUND = 6'b010000,
		ST_DIV   = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [DEG_W-1:0]        deg_q;
	logic [DEG_W-1:0]        top_q;
	logic signed [VW-1:0]    x_q;
	logic signed [VW-1:0]    p1_q;
	logic signed [VW-1:0]    p2_q;
	logic signed [PW-1:0]    prod_s1;
	logic signed [NW-1:0]    num_s2;
	logic                    neg_q;
	logic                    out_valid_q;
	logic [DEG_W-1:0]        out_degree_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_last_q;

	logic                    out_free;
	logic                    put;
	logic                    is_last;
	logic [DEG_W:0]          coef_a;
	logic [DEG_W-1:0]        coef_b;
	logic signed [NW-1:0]    term_a;
	logic signed [NW-1:0]    term_b;
	logic signed [NW-1:0]    num_c;
	logic [NW-1:0]           mag_c;
	logic [NW-1:0]           biased_c;
	logic signed [VW-1:0]    mag_v;
	logic signed [VW-1:0]    new_val;

	div_ctl_t                div_ctl;
	div_sts_t                div_sts;
	logic [DIV_W-1:0]        dividend;
	logic [DIV_W-1:0]        quotient;

	lps_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.sts      (div_sts),
		.quotient (quotient)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign put      = (state_q == ST_PUT) && out_free;
	assign is_last  = (deg_q == top_q);
	assign pop      = (state_q == ST_IDLE) && !q_sts.empty;

	// exact numerator (2i-1) x P1 - (i-1) P2 at scale 2^(2F)
	always_comb begin
		coef_a = {deg_q, 1'b0} - (DEG_W+1)'(1);
		coef_b = deg_q - DEG_W'(1);
		term_a = NW'(prod_s1) * NW'($signed({1'b0, coef_a}));
		term_b = NW'(p2_q) * NW'($signed({1'b0, coef_b}));
		num_c  = term_a - (term_b <<< FRAC_BITS);
	end

	// round half away from zero: |N| + d/2, then divide by i * 2^F
	always_comb begin
		mag_c    = num_s2[NW-1] ? NW'(-num_s2) : NW'(num_s2);
		biased_c = mag_c + (NW'(deg_q) << (FRAC_BITS - 1));
		dividend = DIV_W'(biased_c >> FRAC_BITS);
	end

	assign div_ctl.start   = (state_q == ST_ROUND);
	assign div_ctl.divisor = deg_q;

	// saturate and restore the sign
	always_comb begin
		mag_v   = (quotient > ONE_D) ? ONE_V : VW'(quotient);
		new_val = neg_q ? -mag_v : mag_v;
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			deg_q       <= '0;
			top_q       <= '0;
		end else begin
			if (put)             out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						deg_q   <= '0;
						top_q   <= pop_item.top_degree;
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							deg_q <= deg_q + DEG_W'(1);
							if (deg_q == '0) state_q <= ST_PUT;
							else             state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_sts.done) state_q <= ST_PUT;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// recurrence values, pipeline and output register
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q  <= VW'(pop_item.position);
			p1_q <= ONE_V;
			p2_q <= '0;
		end
		if (put) begin
			out_degree_q <= deg_q;
			out_value_q  <= VAL_W'(p1_q);
			out_last_q   <= is_last;
			if (!is_last && deg_q == '0) begin
				p2_q <= p1_q;
				p1_q <= x_q;
			end
		end
		if (state_q == ST_MUL)   prod_s1 <= x_q * p1_q;
		if (state_q == ST_SCALE) num_s2  <= num_c;
		if (state_q == ST_ROUND) neg_q   <= num_s2[NW-1];
		if (state_q == ST_DIV && div_sts.done) begin
			p2_q <= p1_q;
			p1_q <= new_val;
		end
	end

	assign out_valid  = out_valid_q;
	assign degree     = out_degree_q;
	assign poly_value = out_value_q;
	assign last       = out_last_q;

	`ASSERT_IMPL(a_done_in_div, div_sts.done, state_q == ST_DIV, "divider result unexpected")
	`ASSERT_NEXT(a_last_ends, put && is_last, state_q == ST_IDLE, "series did not end")

endmodule

@@ src/legendre_polynomial_series.sv @@
// Legendre polynomial series P0..Pn at a Q1.F position (Bonnet recurrence).
// Top level; depends on lps_pkg, lps_front, lps_queue, lps_back.
//
//   channel | signals                          | direction
//   config  | cfg_wr_en, cfg_wr_data           | in, write only
//   input   | in_valid, in_stall, position     | in, one position per transaction
//   output  | out_valid, out_stall, degree,    | out, max_degree+1 transactions
//           | poly_value, last                 |   per position
//
// A position leaves the queue from the idle state; degrees 0 and 1 are then
// put straight from the put state, and every higher degree i passes through
// the multiply, scale, round and divide states; the divide state waits for the
// divider by i, which resolves four quotient bits a cycle, before the put.
// One position is worked at a time; a two-entry queue takes further positions.
// Reset is asynchronous, active low, and clears max_degree to 0.
// A stalled result is held in the output register; the next put waits for it.
`timescale 1ns / 1ps

module legendre_polynomial_series #(
	parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lps_pkg::DEG_W-1:0]        cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [lps_pkg::POS_W-1:0] position,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lps_pkg::DEG_W-1:0]        degree,
	output logic signed [lps_pkg::VAL_W-1:0] poly_value,
	output logic                             last
);
	import lps_pkg::*;

	logic   push;
	logic   pop;
	item_t  push_item;
	item_t  pop_item;
	q_sts_t q_sts;

	lps_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.position    (position),
		.q_sts       (q_sts),
		.push        (push),
		.push_item   (push_item)
	);

	lps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.sts       (q_sts)
	);

	lps_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_sts      (q_sts),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.degree     (degree),
		.poly_value (poly_value),
		.last       (last)
	);

endmodule
